### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset.
`define AFM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every edge, reset included.
`define AFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/afm_pkg.sv
package afm_pkg;

  localparam int AFM_MAX_SYMBOLS = 256;
  localparam int SYM_W           = 9;
  localparam int ACT_W           = 2;
  localparam int CNT_W           = 32;
  localparam int REG_W           = 2;

  // Request kinds
  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Register indexes
  localparam logic [REG_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [REG_W-1:0] REG_EOF_INCLUDED = 2'd1;
  localparam logic [REG_W-1:0] REG_INIT_ONE     = 2'd2;
  localparam logic [REG_W-1:0] REG_HALVE_LIMIT  = 2'd3;

  localparam logic [SYM_W-1:0] SYMBOL_COUNT_RST = 9'd256;
  localparam logic [CNT_W-1:0] HALVE_LIMIT_RST  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_count;
    logic             eof_included;
    logic             init_one;
    logic [CNT_W-1:0] halve_limit;
  } afm_cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SYM_W-1:0] symbol_index;
  } afm_req_t;

  typedef struct packed {
    logic             bad_symbol;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] symbol_freq;
    logic [CNT_W-1:0] cum_high;
    logic [CNT_W-1:0] cum_low;
  } afm_res_t;

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

### rtl/afm_core.sv
module afm_core #(
  parameter int MAX_SYMBOLS = afm_pkg::AFM_MAX_SYMBOLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  afm_pkg::afm_req_t req,
  input  afm_pkg::afm_cfg_t cfg,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output afm_pkg::afm_res_t res
);

  localparam int DEPTH = MAX_SYMBOLS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CNT_W = afm_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_NEXT = 4'd2;
  localparam logic [3:0] S_HCHK = 4'd3;
  localparam logic [3:0] S_HALV = 4'd4;
  localparam logic [3:0] S_HEND = 4'd5;
  localparam logic [3:0] S_BUMP = 4'd6;
  localparam logic [3:0] S_BWR  = 4'd7;
  localparam logic [3:0] S_PSUM = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic [afm_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [AW-1:0]             sym_r, sym_nxt;
  logic                      bad_r, bad_nxt;
  logic                      init_r, init_nxt;
  logic                      eofp_r, eofp_nxt;
  logic [CW-1:0]             ii_r, ii_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]          freq_r, freq_nxt;
  logic [CNT_W-1:0]          total_r, total_nxt;
  logic [CNT_W-1:0]          prev_r, prev_nxt;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic [CW-1:0]    usable;
  logic [CW-1:0]    len;
  logic [CNT_W-1:0] halved;

  // Active table length from the configuration
  always_comb begin
    if (32'(cfg.symbol_count) > 32'(MAX_SYMBOLS)) begin
      usable = CW'(MAX_SYMBOLS);
    end else begin
      usable = CW'(cfg.symbol_count);
    end
    len = usable + CW'(cfg.eof_included);
  end

  // Round-up half of the word coming back from memory
  assign halved = (rd_data_r >> 1) + CNT_W'(rd_data_r[0]);

  // Count memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    sym_nxt    = sym_r;
    bad_nxt    = bad_r;
    init_nxt   = init_r;
    eofp_nxt   = eofp_r;
    ii_nxt     = ii_r;
    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    acc_nxt    = acc_r;
    freq_nxt   = freq_r;
    total_nxt  = total_r;
    prev_nxt   = prev_r;
    rd_en      = 1'b0;
    rd_addr    = cnt_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt  = req.action;
          sym_nxt  = AW'(req.symbol_index);
          acc_nxt  = '0;
          freq_nxt = '0;
          cnt_nxt  = '0;
          bad_nxt  = 1'b0;
          case (req.action)
            afm_pkg::ACT_INIT: begin
              init_nxt  = 1'b1;
              eofp_nxt  = cfg.eof_included;
              ii_nxt    = '0;
              state_nxt = S_CLR;
            end
            afm_pkg::ACT_INC, afm_pkg::ACT_QUERY: begin
              if (32'(req.symbol_index) >= 32'(len)) begin
                bad_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else if (req.action == afm_pkg::ACT_INC) begin
                state_nxt = S_HCHK;
              end else begin
                state_nxt = S_PSUM;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Sweep zeros through the whole table
      S_CLR: begin
        wr_en     = 1'b1;
        wr_data   = '0;
        total_nxt = '0;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(DEPTH - 1)) begin
          state_nxt = init_r ? S_NEXT : S_IDLE;
        end
      end

      // Pick the next start-up increment: end-of-file first if included, then each symbol if init_one is set
      S_NEXT: begin
        if (eofp_r) begin
          eofp_nxt  = 1'b0;
          sym_nxt   = AW'(usable);
          state_nxt = S_HCHK;
        end else if (cfg.init_one && (ii_r < usable)) begin
          sym_nxt   = AW'(ii_r);
          ii_nxt    = ii_r + CW'(1);
          state_nxt = S_HCHK;
        end else begin
          acc_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // Decide whether a halving pass comes before the increment
      S_HCHK: begin
        if (total_r >= cfg.halve_limit) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          prev_nxt  = total_r;
          state_nxt = S_HALV;
        end else begin
          state_nxt = S_BUMP;
        end
      end

      // Halve every active count, one read and one write-back per cycle
      S_HALV: begin
        if (cnt_r < len) begin
          rd_en      = 1'b1;
          rd_addr    = cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r;
          wr_data = halved;
          acc_nxt = afm_pkg::sat_add32(acc_r, halved);
        end
        if ((cnt_r >= len) && !rd_vld_r) begin
          state_nxt = S_HEND;
        end
      end

      // Take the new total; stop halving once a pass changes nothing, else recheck the limit
      S_HEND: begin
        total_nxt = acc_r;
        state_nxt = (acc_r == prev_r) ? S_BUMP : S_HCHK;
      end

      S_BUMP: begin
        rd_en     = 1'b1;
        rd_addr   = sym_r;
        state_nxt = S_BWR;
      end

      S_BWR: begin
        wr_en     = 1'b1;
        wr_addr   = sym_r;
        wr_data   = afm_pkg::sat_add32(rd_data_r, CNT_W'(1));
        total_nxt = afm_pkg::sat_add32(total_r, CNT_W'(1));
        if (act_r == afm_pkg::ACT_INIT) begin
          state_nxt = S_NEXT;
        end else begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_PSUM;
        end
      end

      // Sum the counts below the symbol and pick up its own count
      S_PSUM: begin
        if (cnt_r <= CW'(sym_r)) begin
          rd_en      = 1'b1;
          rd_addr    = cnt_r[AW-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (rd_idx_r == sym_r) begin
            freq_nxt = rd_data_r;
          end else begin
            acc_nxt = afm_pkg::sat_add32(acc_r, rd_data_r);
          end
        end
        if ((cnt_r > CW'(sym_r)) && !rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end

      // Hold the result until the output stage takes it
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      init_r   <= 1'b0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      total_r  <= '0;
      eofp_r   <= 1'b0;
      ii_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      total_r  <= total_nxt;
      eofp_r   <= eofp_nxt;
      ii_r     <= ii_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    sym_r    <= sym_nxt;
    bad_r    <= bad_nxt;
    rd_idx_r <= rd_idx_nxt;
    acc_r    <= acc_nxt;
    freq_r   <= freq_nxt;
    prev_r   <= prev_nxt;
  end

  assign idle              = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_DONE);
  assign res.cum_low       = acc_r;
  assign res.cum_high      = afm_pkg::sat_add32(acc_r, freq_r);
  assign res.symbol_freq   = freq_r;
  assign res.total_count   = total_r;
  assign res.bad_symbol    = bad_r;

endmodule

### rtl/adaptive_frequency_model.sv
// Adaptive symbol frequency model for an arithmetic coder. Counts live in one
// single-port-read, single-port-write memory of MAX_SYMBOLS+1 words that a
// sequencer walks one word per cycle, so the block takes one request at a time
// (in_tready is high only while it is idle). A query walks the memory to sum
// the counts below its symbol and to pick up its own count. An increment first
// runs halving passes while the total is at or above halve_limit and a pass
// still lowers it, then bumps the symbol's count before that walk. An init
// clears all MAX_SYMBOLS+1 words and then runs its start-up increments. After
// reset the block runs the same clearing pass before in_tready goes high;
// configuration writes are taken at any time but are meant for when the block
// is idle. A finished result waits in an output register, so the next request
// can enter while it is still being taken.
module adaptive_frequency_model #(
  parameter int MAX_SYMBOLS = afm_pkg::AFM_MAX_SYMBOLS
) (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [8:0] symbol_index, [15:9] zero
  input  logic [1:0]   in_tuser,   // [1:0] action

  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] cum_low, [63:32] cum_high,
                                   // [95:64] symbol_freq, [127:96] total_count
  output logic [0:0]   out_tuser,  // [0] bad_symbol

  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  afm_pkg::afm_cfg_t cfg_r, cfg_nxt;
  afm_pkg::afm_req_t req;
  afm_pkg::afm_res_t res;
  afm_pkg::afm_res_t out_data_r;
  logic              out_vld_r, out_vld_nxt;
  logic              core_idle;
  logic              res_valid;
  logic              res_ready;
  logic              start;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afm_pkg::REG_SYMBOL_COUNT: cfg_nxt.symbol_count = cfg_data[afm_pkg::SYM_W-1:0];
        afm_pkg::REG_EOF_INCLUDED: cfg_nxt.eof_included = cfg_data[0];
        afm_pkg::REG_INIT_ONE:     cfg_nxt.init_one     = cfg_data[0];
        afm_pkg::REG_HALVE_LIMIT:  cfg_nxt.halve_limit  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_count <= afm_pkg::SYMBOL_COUNT_RST;
      cfg_r.eof_included <= 1'b0;
      cfg_r.init_one     <= 1'b0;
      cfg_r.halve_limit  <= afm_pkg::HALVE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input request
  assign in_tready        = core_idle;
  assign start            = in_tvalid && in_tready;
  assign req.action       = in_tuser;
  assign req.symbol_index = in_tdata[afm_pkg::SYM_W-1:0];

  afm_core #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .cfg       (cfg_r),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_data_r.total_count, out_data_r.symbol_freq,
                       out_data_r.cum_high, out_data_r.cum_low};
  assign out_tuser  = out_data_r.bad_symbol;

endmodule

### rtl/afm_checker.sv
`include "assert_macros.svh"

module afm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // A stalled result holds its payload
  `AFM_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

  // No result leaves the block right after reset
  `AFM_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // One request at a time: taking a request makes the block busy
  `AFM_ASSERT(a_busy, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "request taken while busy")

  // A rejected symbol reports empty bounds
  `AFM_ASSERT(a_bad_zero, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (out_tdata[95:0] == 96'd0), "bad symbol with nonzero bounds")

  // The upper bound never falls below the lower bound
  `AFM_ASSERT(a_bounds, clk, rst_n, out_tvalid |-> (out_tdata[63:32] >= out_tdata[31:0]), "cum_high below cum_low")

endmodule

bind adaptive_frequency_model afm_checker u_afm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
